>>> hw/rtl/gaussian_actuator_line_source_macros.svh
// Assertion shorthands used by the checker of this block.
`ifndef GAUSSIAN_ACTUATOR_LINE_SOURCE_MACROS_SVH
`define GAUSSIAN_ACTUATOR_LINE_SOURCE_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define GAL_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GAL_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/gal_pkg.sv
package gal_pkg;

   localparam int MAX_SECTIONS  = 256;
   localparam int FRAC_BITS     = 16;
   localparam int EXP_ENTRIES   = 256;
   localparam int SECTION_WORDS = 16;
   localparam int LANE_W        = 4;
   localparam int COUNT_W       = 9;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_CELL = 1'b1;

   // Table word positions within one section row.
   localparam int W_ROT   = 0;
   localparam int W_POINT = 9;
   localparam int W_LOAD  = 12;
   localparam int W_COEF  = 15;

   typedef struct packed {
      logic               command;
      logic [11:0]        entry_addr;
      logic signed [31:0] word_value;
      logic signed [31:0] cell_x;
      logic signed [31:0] cell_y;
      logic signed [31:0] cell_z;
      logic [31:0]        cell_volume;
      logic [16:0]        load_trunc;
      logic [16:0]        velo_trunc;
      logic signed [31:0] vel_x;
      logic signed [31:0] vel_y;
      logic signed [31:0] vel_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] mom_x_add;
      logic signed [31:0] mom_y_add;
      logic signed [31:0] mom_z_add;
      logic signed [31:0] energy_add;
      logic signed [31:0] gauss_sum_add;
      logic signed [31:0] vel_out_x;
      logic signed [31:0] vel_out_y;
      logic signed [31:0] vel_out_z;
   } rsp_type;

   typedef logic [SECTION_WORDS-1:0][31:0] row_type;

   typedef struct packed {
      logic clear;
      logic finish;
   } ctl_type;

   typedef struct packed {
      logic busy;
   } status_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_DRAIN,
      ST_FINISH,
      ST_RESP
   } state_type;

   function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
      logic signed [79:0] hi;
      logic signed [79:0] lo;
      hi = 80'sd2147483647;
      lo = -80'sd2147483648;
      if (v > hi) begin
         return 32'sh7FFFFFFF;
      end else if (v < lo) begin
         return 32'sh80000000;
      end
      return v[31:0];
   endfunction

   function automatic logic [127:0] div_small(input logic [127:0] t, input int k);
      case (k)
         2:       return t / 2;
         3:       return t / 3;
         4:       return t / 4;
         5:       return t / 5;
         6:       return t / 6;
         7:       return t / 7;
         8:       return t / 8;
         9:       return t / 9;
         10:      return t / 10;
         11:      return t / 11;
         12:      return t / 12;
         default: return t;
      endcase
   endfunction

   // Entry idx of the exp(-r2) table, sampled over r2 in [0,16).
   function automatic logic [15:0] exp_entry(input int idx, input int log2e);
      logic [127:0] h;
      logic [127:0] term;
      logic [127:0] step;
      logic [127:0] v;
      logic [127:0] e;
      h    = 128'(1) << (36 - log2e);
      term = 128'(1) << 32;
      step = term;
      v    = term;
      for (int k = 1; k <= 12; k++) begin
         term = div_small((term * h) >> 32, k);
         if (k[0]) begin
            step = step - term;
         end else begin
            step = step + term;
         end
      end
      for (int i = 0; i < idx; i++) begin
         v = (v * step + 128'h8000_0000) >> 32;
      end
      e = (v + 128'h8000) >> 16;
      return (e > 128'hFFFF) ? 16'hFFFF : e[15:0];
   endfunction

endpackage

>>> hw/rtl/gal_section_mem.sv
module gal_section_mem #(
   parameter int ROWS  = gal_pkg::MAX_SECTIONS,
   parameter int ROW_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        wr_en,
   input  logic [ROW_W-1:0]            wr_row,
   input  logic [gal_pkg::LANE_W-1:0]  wr_lane,
   input  logic [31:0]                 wr_data,
   input  logic                        rd_en,
   input  logic [ROW_W-1:0]            rd_row,
   output logic                        rd_valid,
   output gal_pkg::row_type            rd_data
);

   logic [31:0]      table_ff [ROWS][gal_pkg::SECTION_WORDS];
   gal_pkg::row_type rd_data_ff;
   logic             rd_valid_ff;

   // One word lane written per load, one whole section row read per cycle.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         table_ff[wr_row][wr_lane] <= wr_data;
      end
      if (rd_en) begin
         for (int k = 0; k < gal_pkg::SECTION_WORDS; k++) begin
            rd_data_ff[k] <= table_ff[rd_row][k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= rd_en;
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_data  = rd_data_ff;

endmodule

>>> hw/rtl/gal_datapath.sv
module gal_datapath #(
   parameter int MAX_SECTIONS = gal_pkg::MAX_SECTIONS,
   parameter int FRAC_BITS    = gal_pkg::FRAC_BITS,
   parameter int EXP_ENTRIES  = gal_pkg::EXP_ENTRIES
) (
   input  logic                clock,
   input  logic                reset,
   input  gal_pkg::ctl_type    ctl,
   input  logic                row_valid,
   input  gal_pkg::row_type    row,
   input  gal_pkg::req_type    cell_req,
   output gal_pkg::status_type status,
   output gal_pkg::rsp_type    result
);

   localparam int ACC_W  = 34 + $clog2(MAX_SECTIONS + 1);
   localparam int ROT_W  = FRAC_BITS + 4;
   localparam int SQ_W   = 2 * ROT_W;
   localparam int R2S_W  = SQ_W + 2;
   localparam int IDX_W  = $clog2(EXP_ENTRIES);
   localparam int IP_W   = R2S_W + 13;
   localparam logic signed [66:0] LIM = 67'sd4 <<< FRAC_BITS;
   localparam logic signed [R2S_W-1:0] R2_LIM = R2S_W'(16) << FRAC_BITS;

   logic [15:0] exp_rom [EXP_ENTRIES];

   for (genvar gi = 0; gi < EXP_ENTRIES; gi++) begin : g_exp
      assign exp_rom[gi] = gal_pkg::exp_entry(gi, IDX_W);
   end

   logic signed [31:0] cell_pos [3];
   logic signed [31:0] vel [3];

   assign cell_pos[0] = cell_req.cell_x;
   assign cell_pos[1] = cell_req.cell_y;
   assign cell_pos[2] = cell_req.cell_z;
   assign vel[0]      = cell_req.vel_x;
   assign vel[1]      = cell_req.vel_y;
   assign vel[2]      = cell_req.vel_z;

   // Stage valid bits.
   logic a_valid_ff, b_valid_ff, c_valid_ff, d_valid_ff, e_valid_ff;
   logic g_valid_ff, h_valid_ff, i_valid_ff, j_valid_ff, k_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
         d_valid_ff <= 1'b0;
         e_valid_ff <= 1'b0;
         g_valid_ff <= 1'b0;
         h_valid_ff <= 1'b0;
         i_valid_ff <= 1'b0;
         j_valid_ff <= 1'b0;
         k_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= row_valid;
         b_valid_ff <= a_valid_ff;
         c_valid_ff <= b_valid_ff;
         d_valid_ff <= c_valid_ff;
         e_valid_ff <= d_valid_ff;
         g_valid_ff <= e_valid_ff;
         h_valid_ff <= g_valid_ff;
         i_valid_ff <= h_valid_ff;
         j_valid_ff <= i_valid_ff;
         k_valid_ff <= j_valid_ff;
      end
   end

   assign status.busy = a_valid_ff | b_valid_ff | c_valid_ff | d_valid_ff | e_valid_ff |
                        g_valid_ff | h_valid_ff | i_valid_ff | j_valid_ff | k_valid_ff;

   // Stage A: cell offset and coef times volume.
   logic signed [32:0] a_d_ff [3];
   logic signed [31:0] a_m_ff [9];
   logic signed [31:0] a_f_ff [3];
   logic signed [64:0] a_cv_ff;
   logic signed [32:0] d_in [3];
   logic signed [64:0] cv_in;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         d_in[c] = 33'(cell_pos[c]) - 33'($signed(row[gal_pkg::W_POINT + c]));
      end
      cv_in = $signed(row[gal_pkg::W_COEF]) * $signed({1'b0, cell_req.cell_volume});
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         a_d_ff[c] <= d_in[c];
         a_f_ff[c] <= $signed(row[gal_pkg::W_LOAD + c]);
      end
      for (int k = 0; k < 9; k++) begin
         a_m_ff[k] <= $signed(row[gal_pkg::W_ROT + k]);
      end
      a_cv_ff <= cv_in;
   end

   // Stage B: the nine rotation products.
   logic signed [64:0] b_p_ff [9];
   logic signed [31:0] b_g1_ff;
   logic signed [31:0] b_f_ff [3];

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         for (int j = 0; j < 3; j++) begin
            b_p_ff[3 * r + j] <= a_m_ff[3 * r + j] * a_d_ff[j];
         end
      end
      b_g1_ff <= gal_pkg::sat32(80'(a_cv_ff >>> FRAC_BITS));
      b_f_ff  <= a_f_ff;
   end

   // Stage C: rotated offset and the box test.
   logic signed [66:0]      rot [3];
   logic                    outside;
   logic signed [ROT_W-1:0] c_rot_ff [3];
   logic                    c_out_ff;
   logic signed [31:0]      c_g1_ff;
   logic signed [31:0]      c_f_ff [3];

   always_comb begin
      outside = 1'b0;
      for (int r = 0; r < 3; r++) begin
         rot[r] = 67'(b_p_ff[3 * r] >>> FRAC_BITS) + 67'(b_p_ff[3 * r + 1] >>> FRAC_BITS) +
                  67'(b_p_ff[3 * r + 2] >>> FRAC_BITS);
         if (rot[r] >= LIM || rot[r] <= -LIM) begin
            outside = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int r = 0; r < 3; r++) begin
         c_rot_ff[r] <= rot[r][ROT_W-1:0];
      end
      c_out_ff <= outside;
      c_g1_ff  <= b_g1_ff;
      c_f_ff   <= b_f_ff;
   end

   // Stage D: squared radius and table index.
   logic signed [R2S_W-1:0] sq_sum;
   logic signed [R2S_W-1:0] r2;
   logic [IP_W-1:0]         idx_prod;
   logic [IP_W-1:0]         idx_sh;
   logic [IDX_W-1:0]        idx;
   logic                    hit;
   logic [IDX_W-1:0]        d_idx_ff;
   logic                    d_hit_ff;
   logic signed [31:0]      d_g1_ff;
   logic signed [31:0]      d_f_ff [3];

   always_comb begin
      sq_sum = R2S_W'(c_rot_ff[0] * c_rot_ff[0]) + R2S_W'(c_rot_ff[1] * c_rot_ff[1]) +
               R2S_W'(c_rot_ff[2] * c_rot_ff[2]);
      r2       = sq_sum >>> FRAC_BITS;
      hit      = !c_out_ff && (r2 < R2_LIM);
      idx_prod = IP_W'($unsigned(r2)) * IP_W'(EXP_ENTRIES);
      idx_sh   = idx_prod >> (FRAC_BITS + 4);
      idx      = (idx_sh >= IP_W'(EXP_ENTRIES)) ? IDX_W'(EXP_ENTRIES - 1) : idx_sh[IDX_W-1:0];
   end

   always_ff @(posedge clock) begin
      d_idx_ff <= idx;
      d_hit_ff <= hit;
      d_g1_ff  <= c_g1_ff;
      d_f_ff   <= c_f_ff;
   end

   // Stage E: table read.
   logic [15:0]        e_e_ff;
   logic signed [31:0] e_g1_ff;
   logic signed [31:0] e_f_ff [3];

   always_ff @(posedge clock) begin
      e_e_ff  <= d_hit_ff ? exp_rom[d_idx_ff] : 16'h0000;
      e_g1_ff <= d_g1_ff;
      e_f_ff  <= d_f_ff;
   end

   // Stage G: Gaussian weight product.
   logic signed [48:0] g_gm_ff;
   logic signed [31:0] g_f_ff [3];

   always_ff @(posedge clock) begin
      g_gm_ff <= e_g1_ff * $signed({1'b0, e_e_ff});
      g_f_ff  <= e_f_ff;
   end

   // Stage H: apply truncation weights.
   logic signed [31:0] gauss;
   logic signed [49:0] h_glp_ff;
   logic signed [49:0] h_gvp_ff;
   logic signed [31:0] h_f_ff [3];

   assign gauss = gal_pkg::sat32(80'(g_gm_ff >>> 16));

   always_ff @(posedge clock) begin
      h_glp_ff <= gauss * $signed({1'b0, cell_req.load_trunc});
      h_gvp_ff <= gauss * $signed({1'b0, cell_req.velo_trunc});
      h_f_ff   <= g_f_ff;
   end

   // Stage I: load products.
   logic signed [31:0] gl;
   logic signed [31:0] gv;
   logic signed [63:0] i_fp_ff [3];
   logic signed [31:0] i_gl_ff;
   logic signed [31:0] i_gv_ff;

   assign gl = gal_pkg::sat32(80'(h_glp_ff >>> FRAC_BITS));
   assign gv = gal_pkg::sat32(80'(h_gvp_ff >>> FRAC_BITS));

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         i_fp_ff[c] <= gl * h_f_ff[c];
      end
      i_gl_ff <= gl;
      i_gv_ff <= gv;
   end

   // Stage J: force increments.
   logic signed [31:0] j_gf_ff [3];

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         j_gf_ff[c] <= gal_pkg::sat32(-(80'(i_fp_ff[c] >>> FRAC_BITS)));
      end
   end

   // Stage K: power products.
   logic signed [63:0] k_ep_ff [3];

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         k_ep_ff[c] <= j_gf_ff[c] * vel[c];
      end
   end

   logic signed [31:0] en;

   assign en = gal_pkg::sat32(80'(k_ep_ff[0] >>> FRAC_BITS) + 80'(k_ep_ff[1] >>> FRAC_BITS) +
                              80'(k_ep_ff[2] >>> FRAC_BITS));

   // Accumulators, cleared when a cell transaction starts.
   logic signed [ACC_W-1:0] mom_ff [3];
   logic signed [ACC_W-1:0] energy_ff;
   logic signed [ACC_W-1:0] gsum_ff;
   logic signed [31:0]      gv_last_ff;
   logic signed [63:0]      vel_prod_ff [3];

   always_ff @(posedge clock) begin
      if (ctl.clear) begin
         for (int c = 0; c < 3; c++) begin
            mom_ff[c] <= '0;
         end
         energy_ff  <= '0;
         gsum_ff    <= '0;
         gv_last_ff <= '0;
      end else begin
         if (i_valid_ff) begin
            gsum_ff    <= gsum_ff + ACC_W'(i_gl_ff);
            gv_last_ff <= i_gv_ff;
         end
         if (j_valid_ff) begin
            for (int c = 0; c < 3; c++) begin
               mom_ff[c] <= mom_ff[c] + ACC_W'(j_gf_ff[c]);
            end
         end
         if (k_valid_ff) begin
            energy_ff <= energy_ff + ACC_W'(en);
         end
      end
      if (ctl.finish) begin
         for (int c = 0; c < 3; c++) begin
            vel_prod_ff[c] <= vel[c] * gv_last_ff;
         end
      end
   end

   always_comb begin
      result.mom_x_add     = gal_pkg::sat32(80'(mom_ff[0]));
      result.mom_y_add     = gal_pkg::sat32(80'(mom_ff[1]));
      result.mom_z_add     = gal_pkg::sat32(80'(mom_ff[2]));
      result.energy_add    = gal_pkg::sat32(80'(energy_ff));
      result.gauss_sum_add = gal_pkg::sat32(80'(gsum_ff));
      result.vel_out_x     = gal_pkg::sat32(80'(vel_prod_ff[0] >>> FRAC_BITS));
      result.vel_out_y     = gal_pkg::sat32(80'(vel_prod_ff[1] >>> FRAC_BITS));
      result.vel_out_z     = gal_pkg::sat32(80'(vel_prod_ff[2] >>> FRAC_BITS));
   end

endmodule

>>> hw/rtl/gaussian_actuator_line_source.sv
// Gaussian actuator-line source. A load transaction (command 0) writes one Q16.16 word of
// the section table; the request channel stays ready. A cell transaction (command 1)
// sweeps sections 0 .. min(section_count, MAX_SECTIONS)-1 and returns one response with
// the saturated momentum, energy and Gaussian-sum increments plus the cell velocity
// scaled by the last section's velocity weight. The section table is one memory with one
// 16-word row per section; one row is read per cycle, and a cell lasts for the section
// reads plus the fill and drain of the section pipeline and the response stage. A zero
// count still answers with all-zero fields. Reading a table word never loaded since
// reset gives undefined results. The response register lets a new transaction be
// accepted while a response waits for rsp_ready.
module gaussian_actuator_line_source #(
   parameter int MAX_SECTIONS = gal_pkg::MAX_SECTIONS,
   parameter int FRAC_BITS    = gal_pkg::FRAC_BITS,
   parameter int EXP_ENTRIES  = gal_pkg::EXP_ENTRIES
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  gal_pkg::req_type             req_data,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output gal_pkg::rsp_type             rsp_data,
   input  logic                         csr_we,
   input  logic [gal_pkg::COUNT_W-1:0]  csr_wdata
);

   localparam int ROW_W = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
   localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

   // Section count register.
   logic [gal_pkg::COUNT_W-1:0] section_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         section_count_ff <= gal_pkg::COUNT_W'(1);
      end else if (csr_we) begin
         section_count_ff <= csr_wdata;
      end
   end

   // Clamp the sweep length to the table capacity.
   logic [CNT_W-1:0] count_lim;

   assign count_lim = (32'(section_count_ff) > 32'(MAX_SECTIONS)) ? CNT_W'(MAX_SECTIONS)
                                                                  : CNT_W'(section_count_ff);

   gal_pkg::state_type state_ff, state_in;
   logic [CNT_W-1:0]   sec_ff, sec_in;
   gal_pkg::req_type   cell_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   gal_pkg::rsp_type   rsp_data_ff;
   logic               rsp_load;
   logic               accept;
   logic               rd_en;
   logic               wr_en;
   gal_pkg::ctl_type   ctl;
   gal_pkg::status_type status;
   logic               mem_rd_valid;
   gal_pkg::row_type   mem_rd_data;
   gal_pkg::rsp_type   dp_result;

   assign accept = req_valid && req_ready;

   // Drop loads beyond the table.
   assign wr_en = accept && (req_data.command == gal_pkg::CMD_LOAD) &&
                  (32'(req_data.entry_addr) < 32'(MAX_SECTIONS * gal_pkg::SECTION_WORDS));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gal_pkg::ST_IDLE;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sec_ff       <= sec_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the cell fields for the whole sweep.
   always_ff @(posedge clock) begin
      if (accept) begin
         cell_ff <= req_data;
      end
      if (rsp_load) begin
         rsp_data_ff <= dp_result;
      end
   end

   always_comb begin
      state_in   = state_ff;
      sec_in     = sec_ff;
      req_ready  = 1'b0;
      rd_en      = 1'b0;
      rsp_load   = 1'b0;
      ctl.clear  = 1'b0;
      ctl.finish = 1'b0;
      case (state_ff)
         gal_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            sec_in    = '0;
            if (accept && req_data.command == gal_pkg::CMD_CELL) begin
               ctl.clear = 1'b1;
               state_in  = (count_lim == '0) ? gal_pkg::ST_DRAIN : gal_pkg::ST_SWEEP;
            end
         end
         gal_pkg::ST_SWEEP: begin
            // Issue one section row read per cycle.
            rd_en  = 1'b1;
            sec_in = sec_ff + CNT_W'(1);
            if (sec_in == count_lim) begin
               state_in = gal_pkg::ST_DRAIN;
            end
         end
         gal_pkg::ST_DRAIN: begin
            if (!status.busy && !mem_rd_valid) begin
               state_in = gal_pkg::ST_FINISH;
            end
         end
         gal_pkg::ST_FINISH: begin
            ctl.finish = 1'b1;
            state_in   = gal_pkg::ST_RESP;
         end
         gal_pkg::ST_RESP: begin
            // Wait for the response register to free up.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = gal_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = gal_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   gal_section_mem #(
      .ROWS  (MAX_SECTIONS),
      .ROW_W (ROW_W)
   ) u_mem (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (wr_en),
      .wr_row   (ROW_W'(req_data.entry_addr >> gal_pkg::LANE_W)),
      .wr_lane  (req_data.entry_addr[gal_pkg::LANE_W-1:0]),
      .wr_data  (req_data.word_value),
      .rd_en    (rd_en),
      .rd_row   (ROW_W'(sec_ff)),
      .rd_valid (mem_rd_valid),
      .rd_data  (mem_rd_data)
   );

   gal_datapath #(
      .MAX_SECTIONS (MAX_SECTIONS),
      .FRAC_BITS    (FRAC_BITS),
      .EXP_ENTRIES  (EXP_ENTRIES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .row_valid (mem_rd_valid),
      .row       (mem_rd_data),
      .cell_req  (cell_ff),
      .status    (status),
      .result    (dp_result)
   );

endmodule

>>> hw/rtl/gal_checker.sv
`include "gaussian_actuator_line_source_macros.svh"

module gal_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input gal_pkg::req_type req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input gal_pkg::rsp_type rsp_data
);

   logic cell_acc;
   logic load_acc;

   assign cell_acc = req_valid && req_ready && (req_data.command == gal_pkg::CMD_CELL);
   assign load_acc = req_valid && req_ready && (req_data.command == gal_pkg::CMD_LOAD);

   `GAL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "response dropped")
   `GAL_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_data), "response changed")
   `GAL_ASSERT_NEXT(a_cell_busy, cell_acc, !req_ready, "ready right after cell transaction")
   `GAL_ASSERT_NEXT(a_load_ready, load_acc, req_ready, "load stalled the request channel")
   `GAL_ASSERT_SAME(a_rsp_rise, $rose(rsp_valid), $past(!req_ready), "response while idle")

endmodule

bind gaussian_actuator_line_source gal_checker u_checker (.*);
